[sv/merc_pkg.sv]
`default_nettype none
package merc_pkg;
  localparam int unsigned EndpointsDef = 16;
  localparam int unsigned HeaderBytesDef = 16;
  localparam int unsigned MaxOrderDef = 16;

  typedef enum logic [2:0] {
    CMD_CONFIG = 3'd0,
    CMD_CREDITS = 3'd1,
    CMD_SEND = 3'd2,
    CMD_ACK = 3'd3,
    CMD_ARRIVE = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK = 3'd0,
    ST_NO_CREDIT = 3'd1,
    ST_ACK_ZERO = 3'd2,
    ST_DROPPED = 3'd3,
    ST_CROPPED = 3'd4,
    ST_TOO_LARGE = 3'd5,
    ST_BAD_REFILL = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    KIND_SEND = 2'd0,
    KIND_REPLY = 2'd1,
    KIND_CREDIT = 2'd2,
    KIND_OTHER = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_READ,
    PH_WRITE,
    PH_OUT
  } phase_e;

  typedef struct packed {
    logic [2:0] cmd;
    logic [3:0] endpoint;
    logic [4:0] buf_order;
    logic [4:0] msg_order;
    logic no_ringbuf;
    logic no_header;
    logic [31:0] credit_value;
    logic credit_unlimited;
    logic [15:0] msg_size;
    logic [1:0] rx_kind;
    logic [15:0] refill_amount;
    logic [4:0] refill_endpoint;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [15:0] ring_offset;
    logic [15:0] stored_bytes;
    logic in_ring;
    logic [15:0] msg_count;
    logic [16:0] read_offset;
    logic [31:0] credits_left;
  } rsp_t;
endpackage
`default_nettype wire

[sv/merc_if.sv]
`default_nettype none
interface merc_req_if;
  logic valid;
  logic ready;
  merc_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface merc_rsp_if;
  logic valid;
  logic ready;
  merc_pkg::rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[sv/message_endpoint_ring_credit_unit_core.sv]
// Endpoint bookkeeping for a message unit: ring setup, credits, send
// charging, acknowledge and arrival accounting over a table of endpoints.
// Channels: req (command in) and rsp (one result per command), both
// valid/ready; a transfer happens when valid and ready are high together.
// One command is in flight at a time: accept, memory read, write back, then
// the result register holds the response, and the result is valid once the
// read and write-back phases have passed. Req ready returns in the cycle after
// the result is taken, so a new command is accepted only after the last result.
// The cost is set by the sequence accept, memory read, write back and result
// transfer, one phase each.
// Reset would clear the tables: each entry has a valid bit cleared at reset,
// and an entry not valid reads as zero. No clearing pass is needed.
// If the receiver stalls, the result stays in the output register and no
// new command is accepted until it is taken.
// The credit memory is separate so an arrival reads its own entry and the
// refill target in the same cycle (two read ports).
`default_nettype none
module message_endpoint_ring_credit_unit_core #(
  parameter int unsigned ENDPOINTS = merc_pkg::EndpointsDef,
  parameter int unsigned HEADER_BYTES = merc_pkg::HeaderBytesDef,
  parameter int unsigned MAX_ORDER = merc_pkg::MaxOrderDef
) (
  input wire clk_i,
  input wire rst_ni,
  merc_req_if.sink req_i,
  merc_rsp_if.source rsp_o
);
  import merc_pkg::*;

  localparam int unsigned EW = (ENDPOINTS > 1) ? $clog2(ENDPOINTS) : 1;
  localparam int unsigned OW = MAX_ORDER + 2;

  typedef struct packed {
    logic [4:0] ord;
    logic [4:0] sord;
    logic [1:0] fl;
    logic [OW-1:0] rraw;
    logic [OW-1:0] wraw;
    logic [15:0] cnt;
  } ent_t;

  typedef struct packed {
    logic [31:0] cr;
    logic inf;
  } crd_t;

  ent_t ent_mem [ENDPOINTS];
  crd_t crd_mem [ENDPOINTS];
  logic [ENDPOINTS-1:0] ent_vld_q, crd_vld_q;

  phase_e ph_q, ph_d;
  req_t req_q;
  rsp_t rsp_q, rsp_d;
  ent_t ent_rd_q, ent_cur, ent_wr;
  crd_t crd_rd_q, rcd_rd_q, crd_cur, rcd_cur, crd_wr, rcd_wr;
  logic ent_v_q, crd_v_q, rcd_v_q;
  logic ent_we, crd_we, rcd_we;
  logic [EW-1:0] e_idx, r_idx;
  logic r_ok;
  logic [EW-1:0] ep_map [16];

  // endpoint field folded onto the table size, constant lookup
  for (genvar gi = 0; gi < 16; gi++) begin : g_ep_map
    assign ep_map[gi] = EW'(gi % ENDPOINTS);
  end

  assign e_idx = ep_map[req_q.endpoint];
  assign r_ok = 32'(req_q.refill_endpoint) < ENDPOINTS;
  assign r_idx = EW'(req_q.refill_endpoint);

  always_comb begin
    ph_d = ph_q;
    case (ph_q)
      PH_IDLE: if (req_i.valid) ph_d = PH_READ;
      PH_READ: ph_d = PH_WRITE;
      PH_WRITE: ph_d = PH_OUT;
      PH_OUT: if (rsp_o.ready) ph_d = PH_IDLE;
      default: ph_d = PH_IDLE;
    endcase
  end

  assign req_i.ready = (ph_q == PH_IDLE);
  assign rsp_o.valid = (ph_q == PH_OUT);
  assign rsp_o.data = rsp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ph_q <= PH_IDLE;
    else ph_q <= ph_d;
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) req_q <= req_i.data;
    if (ph_q == PH_READ) begin
      ent_rd_q <= ent_mem[e_idx];
      crd_rd_q <= crd_mem[e_idx];
      rcd_rd_q <= crd_mem[r_idx];
    end
    if (ent_we) ent_mem[e_idx] <= ent_wr;
    if (crd_we) crd_mem[e_idx] <= crd_wr;
    if (rcd_we) crd_mem[r_idx] <= rcd_wr;
    if (ph_q == PH_WRITE) rsp_q <= rsp_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_vld_q <= '0;
      crd_vld_q <= '0;
      ent_v_q <= 1'b0;
      crd_v_q <= 1'b0;
      rcd_v_q <= 1'b0;
    end else begin
      if (ph_q == PH_READ) begin
        ent_v_q <= ent_vld_q[e_idx];
        crd_v_q <= crd_vld_q[e_idx];
        rcd_v_q <= crd_vld_q[r_idx];
      end
      if (ent_we) ent_vld_q[e_idx] <= 1'b1;
      if (crd_we) crd_vld_q[e_idx] <= 1'b1;
      if (rcd_we) crd_vld_q[r_idx] <= 1'b1;
    end
  end

  assign ent_cur = ent_v_q ? ent_rd_q : '0;
  assign crd_cur = crd_v_q ? crd_rd_q : '0;
  assign rcd_cur = rcd_v_q ? rcd_rd_q : '0;

  // arrival arithmetic, widths sized to the order
  logic [OW-1:0] size, wmask, rraw, wraw, roff, woff, slot, avail, res, msgsz;
  logic [OW-1:0] slot_a, smask;
  logic ringbuf, hdr, store, kind_ring, drop, crop, big;
  logic [32:0] refill_sum, need;
  logic [4:0] mo, bo;

  always_comb begin
    size = OW'(1) << ent_cur.ord;
    wmask = (size << 1) - OW'(1);
    rraw = ent_cur.rraw & wmask;
    wraw = ent_cur.wraw & wmask;
    roff = rraw & (size - OW'(1));
    woff = wraw & (size - OW'(1));
    slot = OW'(1) << ent_cur.sord;
    ringbuf = !ent_cur.fl[0];
    hdr = !ent_cur.fl[1];
    store = ringbuf || (req_q.rx_kind == KIND_SEND);
    kind_ring = ringbuf && (req_q.rx_kind == KIND_SEND || req_q.rx_kind == KIND_REPLY);
    avail = size;
    if (ringbuf) begin
      if (wraw == (rraw ^ size)) avail = '0;
      else if (woff >= roff) avail = size - woff + roff;
      else avail = roff - woff;
      if (hdr && avail > slot) avail = slot;
    end
    if (!hdr) avail = avail + OW'(HEADER_BYTES);
    res = OW'(req_q.msg_size);
    drop = 1'b0;
    crop = 1'b0;
    if (store && res > avail) begin
      if (hdr || avail == OW'(HEADER_BYTES)) drop = 1'b1;
      else begin
        res = avail;
        crop = 1'b1;
      end
    end
    if (hdr) msgsz = res;
    else msgsz = (res > OW'(HEADER_BYTES)) ? res - OW'(HEADER_BYTES) : '0;
    big = !drop && store && hdr && msgsz > slot;
    slot_a = hdr ? slot : msgsz;
    refill_sum = {1'b0, rcd_cur.cr} + 33'(req_q.refill_amount);
    need = 33'(req_q.msg_size) + 33'(HEADER_BYTES);
    smask = (OW'(2) << ent_cur.ord) - OW'(1);
    bo = (32'(req_q.buf_order) > MAX_ORDER) ? 5'(MAX_ORDER) : req_q.buf_order;
    mo = (req_q.msg_order > bo) ? bo : req_q.msg_order;
  end

  always_comb begin
    ent_wr = ent_cur;
    crd_wr = crd_cur;
    rcd_wr = rcd_cur;
    ent_we = 1'b0;
    crd_we = 1'b0;
    rcd_we = 1'b0;
    rsp_d = '0;
    rsp_d.status = ST_OK;
    if (ph_q == PH_WRITE) begin
      case (req_q.cmd)
        CMD_CONFIG: begin
          ent_we = 1'b1;
          ent_wr = '0;
          ent_wr.ord = bo;
          ent_wr.sord = mo;
          ent_wr.fl = {req_q.no_header, req_q.no_ringbuf};
        end
        CMD_CREDITS: begin
          crd_we = 1'b1;
          crd_wr.cr = req_q.credit_value;
          crd_wr.inf = req_q.credit_unlimited;
        end
        CMD_SEND: begin
          if (!crd_cur.inf) begin
            if (need > {1'b0, crd_cur.cr}) rsp_d.status = ST_NO_CREDIT;
            else begin
              crd_we = 1'b1;
              crd_wr.cr = crd_cur.cr - need[31:0];
            end
          end
        end
        CMD_ACK: begin
          ent_we = 1'b1;
          if (ringbuf) ent_wr.rraw = (ent_cur.rraw + slot) & smask;
          if (ent_cur.cnt == '0) rsp_d.status = ST_ACK_ZERO;
          else ent_wr.cnt = ent_cur.cnt - 16'd1;
        end
        CMD_ARRIVE: begin
          if (drop) rsp_d.status = ST_DROPPED;
          else if (big) rsp_d.status = ST_TOO_LARGE;
          else begin
            ent_we = 1'b1;
            if (crop) rsp_d.status = ST_CROPPED;
            if (kind_ring) begin
              rsp_d.ring_offset = woff[15:0];
              rsp_d.stored_bytes = msgsz[15:0];
              rsp_d.in_ring = 1'b1;
              ent_wr.wraw = (wraw + slot_a) & wmask;
            end else if (req_q.rx_kind == KIND_SEND) begin
              rsp_d.stored_bytes = msgsz[15:0];
            end
            if (req_q.rx_kind != KIND_CREDIT && ent_cur.cnt != 16'hFFFF)
              ent_wr.cnt = ent_cur.cnt + 16'd1;
            if (!r_ok) rsp_d.status = ST_BAD_REFILL;
            else if (req_q.refill_amount != '0 && !rcd_cur.inf) begin
              rcd_we = 1'b1;
              rcd_wr.cr = refill_sum[32] ? 32'hFFFF_FFFF : refill_sum[31:0];
            end
          end
        end
        default: ;
      endcase
      rsp_d.msg_count = ent_wr.cnt;
      rsp_d.read_offset = 17'(ent_wr.rraw);
      if (rcd_we && r_idx == e_idx) rsp_d.credits_left = rcd_wr.inf ? '1 : rcd_wr.cr;
      else rsp_d.credits_left = crd_wr.inf ? '1 : crd_wr.cr;
    end
  end

  a_one_hot_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({req_i.ready, rsp_o.valid})) else $error("ready with result pending");
  a_write_phase_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ent_we || crd_we || rcd_we) |-> ph_q == PH_WRITE) else $error("stray write");
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && !rsp_o.ready |=> rsp_o.valid && $stable(rsp_q))
    else $error("result changed under stall");
endmodule
`default_nettype wire

[tb/sv/tb_message_endpoint_ring_credit_unit_core.sv]
`timescale 1ns / 100ps
module tb_message_endpoint_ring_credit_unit_core;
  import merc_pkg::*;

  localparam int unsigned NumEp = 16;
  localparam int unsigned HdrBytes = 16;
  localparam int unsigned MaxOrd = 16;
  localparam int unsigned CycleLimit = 400000;

  logic clk_i;
  logic rst_ni;

  merc_req_if req_ch ();
  merc_rsp_if rsp_ch ();

  message_endpoint_ring_credit_unit_core i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_ch.sink),
    .rsp_o  (rsp_ch.source)
  );

  // predictor copy of the endpoint table
  logic [4:0]  ep_ring_ord [NumEp];
  logic [4:0]  ep_slot_ord [NumEp];
  logic        ep_noring   [NumEp];
  logic        ep_nohdr    [NumEp];
  logic [16:0] ep_rd_raw   [NumEp];
  logic [16:0] ep_wr_raw   [NumEp];
  logic [15:0] ep_count    [NumEp];
  logic [31:0] ep_credit_bal [NumEp];
  logic        ep_unlim    [NumEp];

  req_t pending_cmds[$];
  rsp_t expected_rsps[$];
  int   n_errors = 0;
  int   n_cycles = 0;
  bit   no_idle;
  bit   hold_send;
  bit   req_taken;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic rsp_t predict_cmd(req_t r);
    rsp_t o;
    int unsigned e, ord, sord, size, wmask, rraw, wraw, roff, woff, slot;
    int unsigned avail, res, msz, c, amt;
    bit ringbuf, hdr, store, drop;
    o = '0;
    e = r.endpoint;
    drop = 1'b0;
    case (r.cmd)
      CMD_CONFIG: begin
        ord = (r.buf_order > MaxOrd) ? MaxOrd : r.buf_order;
        sord = (r.msg_order > ord) ? ord : r.msg_order;
        ep_ring_ord[e] = ord[4:0];
        ep_slot_ord[e] = sord[4:0];
        ep_noring[e] = r.no_ringbuf;
        ep_nohdr[e] = r.no_header;
        ep_rd_raw[e] = '0;
        ep_wr_raw[e] = '0;
        ep_count[e] = '0;
      end
      CMD_CREDITS: begin
        ep_credit_bal[e] = r.credit_value;
        ep_unlim[e] = r.credit_unlimited;
      end
      CMD_SEND: begin
        if (!ep_unlim[e]) begin
          c = r.msg_size + HdrBytes;
          if (c > ep_credit_bal[e]) o.status = ST_NO_CREDIT;
          else ep_credit_bal[e] = ep_credit_bal[e] - c;
        end
      end
      CMD_ACK: begin
        if (!ep_noring[e]) begin
          wmask = (2 << ep_ring_ord[e]) - 1;
          ep_rd_raw[e] = 17'((ep_rd_raw[e] + (1 << ep_slot_ord[e])) & wmask);
        end
        if (ep_count[e] == 0) o.status = ST_ACK_ZERO;
        else ep_count[e] = ep_count[e] - 16'd1;
      end
      CMD_ARRIVE: begin
        ord = ep_ring_ord[e];
        sord = ep_slot_ord[e];
        ringbuf = !ep_noring[e];
        hdr = !ep_nohdr[e];
        size = 1 << ord;
        wmask = (size << 1) - 1;
        rraw = ep_rd_raw[e] & wmask;
        wraw = ep_wr_raw[e] & wmask;
        roff = rraw & (size - 1);
        woff = wraw & (size - 1);
        slot = 1 << sord;
        res = r.msg_size;
        amt = r.refill_amount;
        store = ringbuf || r.rx_kind == KIND_SEND;
        avail = size;
        if (ringbuf) begin
          if (wraw == (rraw ^ size)) avail = 0;
          else if (woff >= roff) avail = size - woff + roff;
          else avail = roff - woff;
          if (hdr && avail > slot) avail = slot;
        end
        if (!hdr) avail = avail + HdrBytes;
        if (store && res > avail) begin
          if (hdr || avail == HdrBytes) begin
            o.status = ST_DROPPED;
            drop = 1'b1;
          end else begin
            res = avail;
            o.status = ST_CROPPED;
          end
        end
        msz = hdr ? res : ((res > HdrBytes) ? res - HdrBytes : 0);
        if (!drop && store && hdr && msz > slot) begin
          o.status = ST_TOO_LARGE;
          drop = 1'b1;
        end
        if (!drop) begin
          if ((r.rx_kind != KIND_SEND && r.rx_kind != KIND_REPLY) || !ringbuf) begin
            if (r.rx_kind == KIND_SEND) o.stored_bytes = msz[15:0];
          end else begin
            o.ring_offset = woff[15:0];
            o.stored_bytes = msz[15:0];
            o.in_ring = 1'b1;
            ep_wr_raw[e] = 17'((wraw + (hdr ? slot : msz)) & wmask);
          end
          if (r.rx_kind != KIND_CREDIT && ep_count[e] != 16'hFFFF)
            ep_count[e] = ep_count[e] + 16'd1;
          if (r.refill_endpoint >= NumEp) begin
            o.status = ST_BAD_REFILL;
          end else if (amt != 0 && !ep_unlim[r.refill_endpoint]) begin
            c = ep_credit_bal[r.refill_endpoint];
            ep_credit_bal[r.refill_endpoint] =
              (c > 32'hFFFFFFFF - amt) ? 32'hFFFFFFFF : c + amt;
          end
        end
      end
      default: ;
    endcase
    o.msg_count = ep_count[e];
    o.read_offset = ep_rd_raw[e];
    o.credits_left = ep_unlim[e] ? 32'hFFFFFFFF : ep_credit_bal[e];
    return o;
  endfunction

  function automatic req_t rand_cmd(bit tidy);
    req_t r;
    r = '0;
    r.cmd = tidy ? 3'($urandom_range(0, 4)) : 3'($urandom_range(0, 7));
    if (tidy && $urandom_range(0, 9) < 6) r.cmd = CMD_ARRIVE;
    else if (tidy && $urandom_range(0, 9) < 4) r.cmd = CMD_ACK;
    r.endpoint = tidy ? 4'($urandom_range(0, 3)) : 4'($urandom);
    r.buf_order = ($urandom_range(0, 9) < 8) ? 5'($urandom_range(0, 8)) : 5'($urandom);
    r.msg_order = ($urandom_range(0, 9) < 8) ? 5'($urandom_range(0, 6)) : 5'($urandom);
    r.no_ringbuf = ($urandom_range(0, 3) == 0);
    r.no_header = 1'($urandom);
    r.credit_value = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 2000);
    r.credit_unlimited = ($urandom_range(0, 4) == 0);
    r.msg_size = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 150));
    r.rx_kind = 2'($urandom);
    r.refill_amount = ($urandom_range(0, 2) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
    r.refill_endpoint = ($urandom_range(0, 5) == 0) ? 5'($urandom) : 5'($urandom_range(0, 15));
    return r;
  endfunction

  function automatic req_t mk(logic [2:0] c, logic [3:0] ep, logic [4:0] bo,
                              logic [4:0] mo, logic nr, logic nh, logic [31:0] cv,
                              logic cu, logic [15:0] sz, logic [1:0] k,
                              logic [15:0] ra, logic [4:0] re);
    req_t r;
    r = '{c, ep, bo, mo, nr, nh, cv, cu, sz, k, ra, re};
    return r;
  endfunction

  // driver
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_ch.valid <= 1'b0;
      req_ch.data <= '0;
    end else if (!req_ch.valid || req_taken) begin
      // a waiting item holds until the rising edge that transfers it
      if (pending_cmds.size() > 0 && !hold_send &&
          (no_idle || $urandom_range(0, 99) >= 19)) begin
        req_ch.valid <= 1'b1;
        req_ch.data <= pending_cmds[0];
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) rsp_ch.ready <= 1'b0;
    else rsp_ch.ready <= no_idle || $urandom_range(0, 99) >= 19;
  end

  // accept and monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      n_cycles <= n_cycles + 1;
      req_taken <= req_ch.valid && req_ch.ready;
      if (req_ch.valid && req_ch.ready) begin
        expected_rsps.push_back(predict_cmd(req_ch.data));
        void'(pending_cmds.pop_front());
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_rsps.size() == 0) begin
          $display("%0t: unexpected result %h", $time, rsp_ch.data);
          n_errors++;
        end else begin
          if (rsp_ch.data !== expected_rsps[0]) begin
            $display("%0t: mismatch expected %h actual %h", $time,
                     expected_rsps[0], rsp_ch.data);
            if (rsp_ch.data.status !== expected_rsps[0].status)
              $display("%0t:   status expected %0d actual %0d", $time,
                       expected_rsps[0].status, rsp_ch.data.status);
            n_errors++;
          end
          void'(expected_rsps.pop_front());
        end
      end
      if (n_cycles > CycleLimit) begin
        $display("tb_message_endpoint_ring_credit_unit_core failed");
        $finish;
      end
    end else begin
      req_taken <= 1'b0;
      for (int i = 0; i < NumEp; i++) begin
        ep_ring_ord[i] = 0; ep_slot_ord[i] = 0; ep_noring[i] = 0; ep_nohdr[i] = 0;
        ep_rd_raw[i] = 0; ep_wr_raw[i] = 0; ep_count[i] = 0;
        ep_credit_bal[i] = 0; ep_unlim[i] = 0;
      end
    end
  end

  task automatic drain();
    wait (pending_cmds.size() == 0);
    wait (expected_rsps.size() == 0);
    repeat (5) @(posedge clk_i);
  endtask

  initial begin
    no_idle = 0;
    hold_send = 0;
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    // directed
    pending_cmds.push_back(mk(CMD_SEND, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(mk(CMD_ACK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(mk(CMD_CONFIG, 1, 31, 31, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(mk(CMD_CONFIG, 2, 6, 4, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(mk(CMD_CREDITS, 2, 0, 0, 0, 0, 32'hFFFFFFF0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(mk(CMD_SEND, 2, 0, 0, 0, 0, 0, 0, 16'hFFFF, 0, 0, 0));
    pending_cmds.push_back(mk(CMD_SEND, 2, 0, 0, 0, 0, 0, 0, 100, 0, 0, 0));
    pending_cmds.push_back(mk(CMD_ARRIVE, 2, 0, 0, 0, 0, 0, 0, 16, KIND_SEND,
                              16'hFFFF, 2));
    pending_cmds.push_back(mk(CMD_ARRIVE, 2, 0, 0, 0, 0, 0, 0, 17, KIND_REPLY, 1, 31));
    pending_cmds.push_back(mk(CMD_ARRIVE, 2, 0, 0, 0, 0, 0, 0, 32, KIND_SEND, 0, 3));
    pending_cmds.push_back(mk(CMD_ARRIVE, 2, 0, 0, 0, 0, 0, 0, 4, KIND_CREDIT, 5, 2));
    pending_cmds.push_back(mk(CMD_CONFIG, 3, 5, 2, 0, 1, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(mk(CMD_ARRIVE, 3, 0, 0, 0, 0, 0, 0, 8, KIND_SEND, 0, 0));
    pending_cmds.push_back(mk(CMD_ARRIVE, 3, 0, 0, 0, 0, 0, 0, 60, KIND_SEND, 0, 16));
    pending_cmds.push_back(mk(CMD_CONFIG, 4, 4, 2, 1, 0, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(mk(CMD_ARRIVE, 4, 0, 0, 0, 0, 0, 0, 4, KIND_SEND, 0, 0));
    pending_cmds.push_back(mk(CMD_ARRIVE, 4, 0, 0, 0, 0, 0, 0, 4, KIND_OTHER, 0, 0));
    pending_cmds.push_back(mk(CMD_ACK, 4, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(mk(CMD_CREDITS, 5, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0));
    pending_cmds.push_back(mk(CMD_SEND, 5, 0, 0, 0, 0, 0, 0, 16'hFFFF, 0, 0, 0));
    pending_cmds.push_back(mk(CMD_ARRIVE, 6, 0, 0, 0, 0, 0, 0, 16'hFFFF, KIND_REPLY,
                              7, 5));
    pending_cmds.push_back(mk(3'd5, 15, 0, 0, 1, 1, 32'hFFFFFFFF, 1, 16'hFFFF, 3,
                              16'hFFFF, 31));
    pending_cmds.push_back(mk(3'd7, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    // wait until all results are in, then hold the sender back while random commands queue
    drain();
    hold_send = 1;
    for (int i = 0; i < 1500; i++) begin
      pending_cmds.push_back(rand_cmd($urandom_range(0, 9) < 8));
      if (i == 40) hold_send = 0;
      if (i == 600) no_idle = 1;
      if (i == 900) no_idle = 0;
      if (pending_cmds.size() > 50) wait (pending_cmds.size() < 10);
    end
    hold_send = 0;
    drain();
    repeat (20) @(posedge clk_i);
    if (n_errors == 0) $display("tb_message_endpoint_ring_credit_unit_core passed");
    else $display("tb_message_endpoint_ring_credit_unit_core failed");
    $finish;
  end
endmodule

[filelist.f]
sv/merc_pkg.sv
sv/merc_if.sv
sv/message_endpoint_ring_credit_unit_core.sv
tb/sv/tb_message_endpoint_ring_credit_unit_core.sv
